>>> src/bce_pkg.sv
// Shared types, widths, constants and the discharge curve of the battery charge estimator.
// No dependencies; every other file of the block imports this package.
package bce_pkg;

  // Field widths
  localparam int RAW_W   = 16;
  localparam int CODE_W  = 15;
  localparam int PCT_W   = 7;
  localparam int LSB_W   = 14;
  localparam int ALPHA_W = 9;
  localparam int CUR_W   = 30;
  localparam int PWR_W   = 35;
  localparam int POWER_SHIFT = 5;   // power LSB is 32 current LSBs

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 14;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LSB = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_SMOOTH_ALPHA = CFG_IDX_W'(1);
  localparam logic [LSB_W-1:0]   LSB_RESET   = LSB_W'(1000);
  localparam logic [ALPHA_W-1:0] ALPHA_RESET = ALPHA_W'(26);
  localparam logic [ALPHA_W-1:0] ALPHA_MIN   = ALPHA_W'(1);
  localparam logic [ALPHA_W-1:0] ALPHA_ONE   = ALPHA_W'(256);
  localparam int ALPHA_FRAC = 8;     // alpha is Q1.8
  localparam int ROUND_HALF = 128;   // one half in alpha's fraction

  localparam int DEF_FRACTION_BITS = 8;
  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // Curve table
  localparam int CURVE_POINTS = 19;
  localparam int TABLE_SLOTS  = 32;
  localparam int IDX_W        = 5;
  localparam int N_PTS = (CURVE_POINTS > TABLE_SLOTS) ? TABLE_SLOTS :
                         ((CURVE_POINTS < 2) ? 2 : CURVE_POINTS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(N_PTS - 1);

  // Interpolation divider
  localparam int NUM_W     = CODE_W + PCT_W + 2;
  localparam int DEN_W     = CODE_W + 1;
  localparam int DIV_STEPS = PCT_W;
  localparam int CNT_W     = $clog2(DIV_STEPS);

  function automatic logic [CODE_W-1:0] curve_code(input logic [IDX_W-1:0] i);
    logic [CODE_W-1:0] c;
    case (i)
      5'd0:  c = 15'd10500;
      5'd1:  c = 15'd10375;
      5'd2:  c = 15'd10250;
      5'd3:  c = 15'd10125;
      5'd4:  c = 15'd10000;
      5'd5:  c = 15'd9875;
      5'd6:  c = 15'd9750;
      5'd7:  c = 15'd9625;
      5'd8:  c = 15'd9500;
      5'd9:  c = 15'd9375;
      5'd10: c = 15'd9250;
      5'd11: c = 15'd9125;
      5'd12: c = 15'd9000;
      5'd13: c = 15'd8875;
      5'd14: c = 15'd8750;
      5'd15: c = 15'd8625;
      5'd16: c = 15'd8500;
      5'd17: c = 15'd8250;
      5'd18: c = 15'd7500;
      default: c = '0;
    endcase
    return c;
  endfunction

  function automatic logic [PCT_W-1:0] curve_pct(input logic [IDX_W-1:0] i);
    logic [PCT_W-1:0] p;
    case (i)
      5'd0:  p = 7'd100;
      5'd1:  p = 7'd98;
      5'd2:  p = 7'd95;
      5'd3:  p = 7'd90;
      5'd4:  p = 7'd85;
      5'd5:  p = 7'd78;
      5'd6:  p = 7'd70;
      5'd7:  p = 7'd62;
      5'd8:  p = 7'd54;
      5'd9:  p = 7'd46;
      5'd10: p = 7'd38;
      5'd11: p = 7'd30;
      5'd12: p = 7'd22;
      5'd13: p = 7'd15;
      5'd14: p = 7'd10;
      5'd15: p = 7'd6;
      5'd16: p = 7'd3;
      5'd17: p = 7'd1;
      default: p = '0;
    endcase
    return p;
  endfunction

  // Controller to datapath commands
  typedef struct packed {
    logic load;
    logic seg_next;
    logic take_end;
    logic take_flat;
    logic mul_load;
    logic div_step;
    logic take_quot;
    logic filt_mul;
    logic filt_add;
    logic pct_update;
    logic out_load;
  } bce_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic ok;
    logic end_hit;
    logic seg_hit;
    logic span_zero;
    logic primed;
    logic div_last;
    logic out_free;
  } bce_sts_t;

endpackage

>>> src/bce_if.sv
// Channel interfaces of the battery charge estimator: input items, result items, config writes.
// Depends on bce_pkg for field widths.
interface bce_in_if import bce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    read_ok;
  logic [RAW_W-1:0]        raw_bus_voltage;
  logic signed [RAW_W-1:0] raw_current;
  logic [RAW_W-1:0]        raw_power;

  modport source (output valid, read_ok, raw_bus_voltage, raw_current, raw_power,
                  input ready);
  modport sink (input valid, read_ok, raw_bus_voltage, raw_current, raw_power,
                output ready);
endinterface

interface bce_out_if import bce_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic                    available;
  logic [CODE_W-1:0]       voltage_code;
  logic signed [CUR_W-1:0] current_microamps;
  logic [PWR_W-1:0]        power_microwatts;
  logic [PCT_W-1:0]        charge_percent;

  modport source (output valid, available, voltage_code, current_microamps,
                  power_microwatts, charge_percent, input ready);
  modport sink (input valid, available, voltage_code, current_microamps,
                power_microwatts, charge_percent, output ready);
endinterface

interface bce_cfg_if import bce_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/bce_ctrl.sv
// Sequencer of the battery charge estimator: walks one item through search, divide and filter.
// Depends on bce_pkg for the command and status structs.
module bce_ctrl import bce_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  bce_sts_t sts,
  output bce_cmd_t cmd
);

  typedef enum logic [8:0] {
    ST_IDLE   = 9'b000000001,
    ST_SEARCH = 9'b000000010,
    ST_MUL    = 9'b000000100,
    ST_DIV    = 9'b000001000,
    ST_QUOT   = 9'b000010000,
    ST_FMUL   = 9'b000100000,
    ST_FADD   = 9'b001000000,
    ST_ROUND  = 9'b010000000,
    ST_OUT    = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!sts.ok) begin
          state_nxt = ST_OUT;
        end else if (sts.end_hit) begin
          cmd.take_end = 1'b1;
          state_nxt    = ST_FMUL;
        end else if (sts.seg_hit && sts.span_zero) begin
          cmd.take_flat = 1'b1;
          state_nxt     = ST_FMUL;
        end else if (sts.seg_hit) begin
          state_nxt = ST_MUL;
        end else begin
          cmd.seg_next = 1'b1;
        end
      end
      ST_MUL: begin
        cmd.mul_load = 1'b1;
        state_nxt    = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = ST_QUOT;
        end
      end
      ST_QUOT: begin
        cmd.take_quot = 1'b1;
        state_nxt     = ST_FMUL;
      end
      ST_FMUL: begin
        cmd.filt_mul = 1'b1;
        state_nxt    = sts.primed ? ST_FADD : ST_ROUND;
      end
      ST_FADD: begin
        cmd.filt_add = 1'b1;
        state_nxt    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.pct_update = 1'b1;
        state_nxt      = ST_OUT;
      end
      ST_OUT: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_ready)
    else $error("input taken while an item is in flight");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |-> sts.out_free)
    else $error("result loaded over an untaken result");

  a_add_when_primed: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.filt_add |-> sts.primed)
    else $error("filter update on an unprimed filter");

endmodule

>>> src/bce_dpath.sv
// Datapath of the battery charge estimator: config registers, curve lookup, divider, filter,
// held values and the result register. Depends on bce_pkg.
module bce_dpath import bce_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  bce_cmd_t                cmd,
  output bce_sts_t                sts,
  input  logic                    in_read_ok,
  input  logic [RAW_W-1:0]        in_raw_bus_voltage,
  input  logic signed [RAW_W-1:0] in_raw_current,
  input  logic [RAW_W-1:0]        in_raw_power,
  input  logic                    cfg_we,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_DATA_W-1:0]   cfg_data,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_available,
  output logic [CODE_W-1:0]       out_voltage_code,
  output logic signed [CUR_W-1:0] out_current_microamps,
  output logic [PWR_W-1:0]        out_power_microwatts,
  output logic [PCT_W-1:0]        out_charge_percent
);

  localparam int LVL_W  = PCT_W + FRACTION_BITS;
  localparam int PROD_W = LVL_W + 1 + ALPHA_W + 1;
  localparam logic [LVL_W:0] LVL_HALF = (LVL_W+1)'(1) << (FRACTION_BITS - 1);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(PCT_MAX) << FRACTION_BITS;

  // Configuration
  logic [LSB_W-1:0]   lsb_r;
  logic [ALPHA_W-1:0] alpha_r;

  // Item state
  logic                    ok_r;
  logic                    primed_r;
  logic [CODE_W-1:0]       held_voltage_r;
  logic signed [RAW_W-1:0] held_current_r;
  logic [RAW_W-1:0]        held_power_r;
  logic [PCT_W-1:0]        held_percent_r;
  logic [LVL_W-1:0]        level_r;
  logic [IDX_W-1:0]        idx_r;
  logic [NUM_W-1:0]        num_r;
  logic [DEN_W-1:0]        den_r;
  logic [PCT_W-1:0]        q_r;
  logic [CNT_W-1:0]        cnt_r;
  logic [PCT_W-1:0]        plo_r;
  logic [PCT_W-1:0]        inst_r;
  logic signed [PROD_W-1:0] fprod_r;

  // Result register
  logic                    out_valid_r;
  logic                    out_available_r;
  logic [CODE_W-1:0]       out_voltage_r;
  logic signed [CUR_W-1:0] out_current_r;
  logic [PWR_W-1:0]        out_power_r;
  logic [PCT_W-1:0]        out_percent_r;

  // Segment lookup
  logic [IDX_W-1:0]  idx_up;
  logic [CODE_W-1:0] seg_hi, seg_lo, span, diff;
  logic [PCT_W-1:0]  pct_hi, pct_lo, dpct;
  logic [CODE_W+PCT_W-1:0] mprod;
  logic [NUM_W-1:0]  num_nxt, trial;
  logic [PCT_W:0]    qsum;

  assign idx_up = idx_r + IDX_W'(1);
  assign seg_hi = curve_code(idx_r);
  assign seg_lo = curve_code(idx_up);
  assign pct_hi = curve_pct(idx_r);
  assign pct_lo = curve_pct(idx_up);
  assign span   = seg_hi - seg_lo;
  assign diff   = held_voltage_r - seg_lo;
  assign dpct   = pct_hi - pct_lo;
  assign mprod  = diff * dpct;
  assign num_nxt = {1'b0, mprod, 1'b0} + NUM_W'(span);
  assign trial  = NUM_W'(den_r) << cnt_r;
  assign qsum   = {1'b0, plo_r} + {1'b0, q_r};

  // Filter
  logic [ALPHA_W-1:0]       alpha_eff;
  logic signed [LVL_W:0]    delta;
  logic signed [PROD_W-1:0] fprod_nxt, fsum, fstep, lvl_sum;
  logic [LVL_W:0]           lvl_rnd;
  logic [PCT_W:0]           pct_raw;

  always_comb begin
    if (alpha_r == '0) begin
      alpha_eff = ALPHA_MIN;
    end else if (alpha_r > ALPHA_ONE) begin
      alpha_eff = ALPHA_ONE;
    end else begin
      alpha_eff = alpha_r;
    end
  end

  assign delta     = $signed({1'b0, inst_r, {FRACTION_BITS{1'b0}}})
                   - $signed({1'b0, level_r});
  assign fprod_nxt = delta * $signed({1'b0, alpha_eff});
  assign fsum      = fprod_r + $signed(PROD_W'(ROUND_HALF));
  assign fstep     = fsum >>> ALPHA_FRAC;
  assign lvl_sum   = $signed({{(PROD_W-LVL_W){1'b0}}, level_r}) + fstep;
  assign lvl_rnd   = {1'b0, level_r} + LVL_HALF;
  assign pct_raw   = lvl_rnd[LVL_W:FRACTION_BITS];

  // Scaling of held readings
  logic signed [RAW_W+LSB_W:0] cur_prod;
  logic [RAW_W+LSB_W-1:0]      pwr_prod;

  assign cur_prod = held_current_r * $signed({1'b0, lsb_r});
  assign pwr_prod = held_power_r * lsb_r;

  // Status
  assign sts.ok        = ok_r;
  assign sts.end_hit   = (held_voltage_r >= curve_code('0))
                      || (held_voltage_r <= curve_code(LAST_IDX));
  assign sts.seg_hit   = (held_voltage_r <= seg_hi) && (held_voltage_r >= seg_lo);
  assign sts.span_zero = (seg_hi == seg_lo);
  assign sts.primed    = primed_r;
  assign sts.div_last  = (cnt_r == '0);
  assign sts.out_free  = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lsb_r   <= LSB_RESET;
      alpha_r <= ALPHA_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CURRENT_LSB:  lsb_r   <= cfg_data[LSB_W-1:0];
        REG_SMOOTH_ALPHA: alpha_r <= cfg_data[ALPHA_W-1:0];
        default: ;
      endcase
    end
  end

  // Model state, cleared at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ok_r           <= 1'b0;
      primed_r       <= 1'b0;
      held_voltage_r <= '0;
      held_current_r <= '0;
      held_power_r   <= '0;
      held_percent_r <= '0;
      level_r        <= '0;
    end else begin
      if (cmd.load) begin
        ok_r <= in_read_ok;
        if (in_read_ok) begin
          held_voltage_r <= in_raw_bus_voltage[CODE_W-1:0];
          held_current_r <= in_raw_current;
          held_power_r   <= in_raw_power;
        end else begin
          primed_r <= 1'b0;
        end
      end
      if (cmd.filt_mul && !primed_r) begin
        level_r  <= {inst_r, {FRACTION_BITS{1'b0}}};
        primed_r <= 1'b1;
      end
      if (cmd.filt_add) begin
        level_r <= lvl_sum[LVL_W-1:0];
      end
      if (cmd.pct_update) begin
        held_percent_r <= (pct_raw > {1'b0, PCT_MAX}) ? PCT_MAX : pct_raw[PCT_W-1:0];
      end
    end
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx_r <= '0;
    end else if (cmd.seg_next) begin
      idx_r <= idx_up;
    end
    if (cmd.take_end) begin
      inst_r <= (held_voltage_r >= curve_code('0)) ? PCT_MAX : '0;
    end
    if (cmd.take_flat) begin
      inst_r <= (pct_hi > PCT_MAX) ? PCT_MAX : pct_hi;
    end
    if (cmd.mul_load) begin
      num_r <= num_nxt;
      den_r <= {span, 1'b0};
      plo_r <= pct_lo;
      q_r   <= '0;
      cnt_r <= CNT_W'(DIV_STEPS - 1);
    end
    if (cmd.div_step) begin
      if (num_r >= trial) begin
        num_r     <= num_r - trial;
        q_r[cnt_r] <= 1'b1;
      end
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.take_quot) begin
      inst_r <= (qsum > {1'b0, PCT_MAX}) ? PCT_MAX : qsum[PCT_W-1:0];
    end
    if (cmd.filt_mul) begin
      fprod_r <= fprod_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_available_r <= ok_r;
      out_voltage_r   <= held_voltage_r;
      out_current_r   <= cur_prod[CUR_W-1:0];
      out_power_r     <= {pwr_prod, {POWER_SHIFT{1'b0}}};
      out_percent_r   <= held_percent_r;
    end
  end

  assign out_valid             = out_valid_r;
  assign out_available         = out_available_r;
  assign out_voltage_code      = out_voltage_r;
  assign out_current_microamps = out_current_r;
  assign out_power_microwatts  = out_power_r;
  assign out_charge_percent    = out_percent_r;

  a_percent_range: assert property (@(posedge clk) disable iff (!rst_n)
    held_percent_r <= PCT_MAX)
    else $error("held percent above full scale");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= LVL_MAX)
    else $error("filter level above full scale");

  a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_load |=> out_valid_r)
    else $error("loaded result not presented");

endmodule

>>> src/battery_charge_estimator_unit.sv
// Top level of the battery charge estimator: channel interfaces, controller and datapath.
// Depends on bce_pkg, bce_if, bce_ctrl and bce_dpath.
//
// Each input item is one set of power-monitor readings and yields exactly one result item.
// A good read (read_ok high) maps the 15-bit voltage code onto a 4S charge curve: a
// sequencer walks the curve one segment per cycle, a small multiply builds the
// interpolation numerator and a restoring divider produces the percent one quotient bit a
// cycle. The percent then passes an exponential filter (a multiply step, an add step and
// a rounding step); the first good read after reset or after a failed read seeds the
// filter directly and skips the add step. A failed read skips all of this, reports
// available low and repeats the last good values. Current and power are scaled by
// current_lsb_microamps as the result is loaded. How long one item occupies the block
// depends on its path: a failed read goes straight to the output, a code at or beyond a
// curve end skips the segment walk and the divider, and otherwise the segment search and
// the divider set it, less the add step when the read seeds the filter. The block also
// waits while the output register still holds an untaken result. The next item is taken as
// soon as the result sits in the output register, even if it has not been taken yet.
// Configuration writes are always accepted; write them only while idle.
module battery_charge_estimator_unit import bce_pkg::*; #(
  parameter int FRACTION_BITS = DEF_FRACTION_BITS
) (
  input logic         clk,
  input logic         rst_n,
  bce_in_if.sink      in_ch,
  bce_out_if.source   out_ch,
  bce_cfg_if.sink     cfg_ch
);

  bce_cmd_t cmd;
  bce_sts_t sts;
  logic     cfg_we;

  // Config writes never stall
  assign cfg_ch.ready = 1'b1;
  assign cfg_we       = cfg_ch.valid && cfg_ch.ready;

  bce_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bce_dpath #(
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dpath (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cmd                   (cmd),
    .sts                   (sts),
    .in_read_ok            (in_ch.read_ok),
    .in_raw_bus_voltage    (in_ch.raw_bus_voltage),
    .in_raw_current        (in_ch.raw_current),
    .in_raw_power          (in_ch.raw_power),
    .cfg_we                (cfg_we),
    .cfg_index             (cfg_ch.index),
    .cfg_data              (cfg_ch.data),
    .out_valid             (out_ch.valid),
    .out_ready             (out_ch.ready),
    .out_available         (out_ch.available),
    .out_voltage_code      (out_ch.voltage_code),
    .out_current_microamps (out_ch.current_microamps),
    .out_power_microwatts  (out_ch.power_microwatts),
    .out_charge_percent    (out_ch.charge_percent)
  );

endmodule

>>> test/tb_battery_charge_estimator_unit.sv
`timescale 1ns / 1ps
// Testbench of battery_charge_estimator_unit: random and directed power-monitor readings,
// each report checked against a cycle-free predictor. Uses bce_pkg and the bce_*_if channels.
module tb_battery_charge_estimator_unit;
  import bce_pkg::*;

  localparam int FRAC        = DEF_FRACTION_BITS;
  localparam int STALL_LIMIT = 2000;   // cycles with no handshake on any channel
  localparam int TAIL_CYCLES = 64;     // settle time after the last report
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 163;
  localparam int MAX_SHOWN   = 10;

  // Indexes with no register behind them; writes there must change nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct packed {
    logic             ok;
    logic [RAW_W-1:0] volt;
    logic [RAW_W-1:0] cur;
    logic [RAW_W-1:0] pwr;
  } reading_t;

  typedef struct packed {
    logic             available;
    logic [CODE_W-1:0] volt;
    logic [CUR_W-1:0]  cur;
    logic [PWR_W-1:0]  pwr;
    logic [PCT_W-1:0]  pct;
  } report_t;

  logic clk;
  logic rst_n;

  bce_in_if  in_ch ();
  bce_out_if out_ch ();
  bce_cfg_if cfg_ch ();

  battery_charge_estimator_unit i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // 4S discharge curve: voltage code at each knee and the charge percent there.
  int knee_code [0:18] = '{10500, 10375, 10250, 10125, 10000, 9875, 9750, 9625, 9500,
                           9375, 9250, 9125, 9000, 8875, 8750, 8625, 8500, 8250, 7500};
  int knee_pct  [0:18] = '{100, 98, 95, 90, 85, 78, 70, 62, 54, 46, 38, 30, 22, 15, 10,
                           6, 3, 1, 0};

  // Predictor state: configuration, filter and the last good readings.
  logic [LSB_W-1:0]   lsb_ua;
  logic [ALPHA_W-1:0] alpha_q;
  longint             level_q;
  logic               primed_q;
  logic [CODE_W-1:0]  hold_volt;
  logic [RAW_W-1:0]   hold_cur;
  logic [RAW_W-1:0]   hold_pwr;
  logic [PCT_W-1:0]   hold_pct;

  reading_t reading_q [$];   // readings waiting for the driver
  report_t  report_q  [$];   // reports owed by the block, oldest first
  int readings_queued;
  int readings_taken;
  int bad_reports;
  int idle_cycles;
  bit in_took;               // input item taken at the last rising edge
  bit calm;                  // no idling on either side
  int in_gap;
  int out_hold;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Instant percent from the voltage code: ends saturate, segments interpolate with
  // round half up on the half-step.
  function automatic int instant_pct(int code);
    int span;
    int num;
    int p;
    if (code >= knee_code[0]) return 100;
    if (code <= knee_code[18]) return 0;
    for (int k = 0; k < 18; k++) begin
      if (code <= knee_code[k] && code >= knee_code[k+1]) begin
        span = knee_code[k] - knee_code[k+1];
        if (span <= 0) return knee_pct[k];
        num = 2 * (code - knee_code[k+1]) * (knee_pct[k] - knee_pct[k+1]) + span;
        p = knee_pct[k+1] + num / (2 * span);
        return (p > 100) ? 100 : ((p < 0) ? 0 : p);
      end
    end
    return 0;
  endfunction

  // Advance the predictor by one accepted reading and return the report it owes.
  function automatic report_t predict_report(reading_t r);
    longint  a;
    longint  delta;
    longint  prod;
    longint  p;
    longint  cur;
    logic [63:0] pwr;
    int      inst;
    report_t e;
    if (r.ok) begin
      hold_volt = r.volt[CODE_W-1:0];
      hold_cur  = r.cur;
      hold_pwr  = r.pwr;
      inst = instant_pct(int'(hold_volt));
      if (!primed_q) begin
        level_q  = longint'(inst) <<< FRAC;
        primed_q = 1'b1;
      end else begin
        a = longint'(alpha_q);
        if (a < 1) a = 1;
        if (a > 256) a = 256;
        delta   = (longint'(inst) <<< FRAC) - level_q;
        prod    = a * delta + ROUND_HALF;
        level_q = level_q + (prod >>> ALPHA_FRAC);   // floor on negative steps
      end
      p = (level_q + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
      hold_pct = (p > 100) ? PCT_MAX : PCT_W'(p);
    end else begin
      primed_q = 1'b0;
    end
    // Held raw values are rescaled with the present LSB, also on a failed read.
    cur = longint'($signed(hold_cur)) * longint'(lsb_ua);
    pwr = 64'(hold_pwr) * 64'(lsb_ua);
    pwr = pwr << POWER_SHIFT;
    e.available = r.ok && primed_q;
    e.volt      = hold_volt;
    e.cur       = cur[CUR_W-1:0];
    e.pwr       = pwr[PWR_W-1:0];
    e.pct       = hold_pct;
    return e;
  endfunction

  function automatic reading_t random_reading();
    reading_t r;
    int pick;
    r.ok  = ($urandom_range(0, 9) != 0);
    r.cur = RAW_W'($urandom);
    r.pwr = RAW_W'($urandom);
    pick  = $urandom_range(0, 9);
    if (pick == 0)
      r.volt = RAW_W'($urandom);
    else if (pick == 1)
      r.volt = RAW_W'(knee_code[$urandom_range(0, 18)] + $urandom_range(0, 2) - 1);
    else
      r.volt = RAW_W'($urandom_range(7400, 10600));
    // The top bit is not part of the code; flip it now and then.
    if ($urandom_range(0, 3) == 0) r.volt[RAW_W-1] = 1'b1;
    return r;
  endfunction

  task automatic queue_reading(input logic ok, input logic [RAW_W-1:0] volt,
                               input logic [RAW_W-1:0] cur, input logic [RAW_W-1:0] pwr);
    reading_t r;
    r.ok   = ok;
    r.volt = volt;
    r.cur  = cur;
    r.pwr  = pwr;
    reading_q.push_back(r);
    readings_queued++;
  endtask

  // Write one register; hold valid until the block takes the item, then drop it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // Wait until every queued reading went in and every owed report came out.
  task automatic drain();
    while (readings_taken != readings_queued || report_q.size() != 0) @(negedge clk);
  endtask

  // Input driver: advance to the next reading once the current one is taken, with
  // random gaps between items.
  always @(negedge clk) begin
    if (in_took || !in_ch.valid) begin
      if (in_gap > 0) begin
        in_gap--;
        in_ch.valid <= 1'b0;
      end else if (!calm && reading_q.size() != 0 && $urandom_range(0, 7) == 0) begin
        in_gap = $urandom_range(0, 7);
        in_ch.valid <= 1'b0;
      end else if (reading_q.size() != 0) begin
        reading_t r;
        r = reading_q.pop_front();
        in_ch.valid           <= 1'b1;
        in_ch.read_ok         <= r.ok;
        in_ch.raw_bus_voltage <= r.volt;
        in_ch.raw_current     <= r.cur;
        in_ch.raw_power       <= r.pwr;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: ready drops in random bursts.
  always @(negedge clk) begin
    if (out_hold > 0) begin
      out_hold--;
      out_ch.ready <= 1'b0;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      out_hold = $urandom_range(0, 7);
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  // Monitor: track config writes, predict on every taken reading, check every report.
  always @(posedge clk) begin
    report_t e;
    report_t got;
    reading_t r;
    bit cfg_took;
    bit out_took;
    in_took  = rst_n && in_ch.valid && in_ch.ready;
    cfg_took = rst_n && cfg_ch.valid && cfg_ch.ready;
    out_took = rst_n && out_ch.valid && out_ch.ready;

    if (cfg_took) begin
      // Only the low bits of each register are kept; spare indexes are dropped.
      if (cfg_ch.index == REG_CURRENT_LSB)
        lsb_ua = cfg_ch.data[LSB_W-1:0];
      else if (cfg_ch.index == REG_SMOOTH_ALPHA)
        alpha_q = cfg_ch.data[ALPHA_W-1:0];
    end

    if (in_took) begin
      r.ok   = in_ch.read_ok;
      r.volt = in_ch.raw_bus_voltage;
      r.cur  = in_ch.raw_current;
      r.pwr  = in_ch.raw_power;
      report_q.push_back(predict_report(r));
      readings_taken++;
    end

    if (out_took) begin
      got.available = out_ch.available;
      got.volt      = out_ch.voltage_code;
      got.cur       = out_ch.current_microamps;
      got.pwr       = out_ch.power_microwatts;
      got.pct       = out_ch.charge_percent;
      if (report_q.size() == 0) begin
        bad_reports++;
        if (bad_reports <= MAX_SHOWN)
          $display("%0t: report with none owed: avail=%0b volt=%0d cur=%0d pwr=%0d pct=%0d",
                   $realtime, got.available, got.volt, $signed(got.cur), got.pwr, got.pct);
      end else begin
        e = report_q.pop_front();
        if (got.available !== e.available || got.volt !== e.volt || got.cur !== e.cur ||
            got.pwr !== e.pwr || got.pct !== e.pct) begin
          bad_reports++;
          if (bad_reports <= MAX_SHOWN) begin
            $display("%0t: report mismatch", $realtime);
            $display("  exp avail=%0b volt=%0d cur=%0d pwr=%0d pct=%0d",
                     e.available, e.volt, $signed(e.cur), e.pwr, e.pct);
            $display("  got avail=%0b volt=%0d cur=%0d pwr=%0d pct=%0d",
                     got.available, got.volt, $signed(got.cur), got.pwr, got.pct);
          end
        end
      end
    end

    // Watchdog: a hung handshake ends the run.
    if (in_took || cfg_took || out_took) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("tb_battery_charge_estimator_unit NOT OK");
        $finish;
      end
    end
  end

  initial begin
    reading_t r;
    logic [LSB_W-1:0]   lsb_plan   [PHASES];
    logic [ALPHA_W-1:0] alpha_plan [PHASES];

    // Known values on every input from time zero; predictor at its reset state.
    rst_n                 = 1'b0;
    in_ch.valid           = 1'b0;
    in_ch.read_ok         = 1'b0;
    in_ch.raw_bus_voltage = '0;
    in_ch.raw_current     = '0;
    in_ch.raw_power       = '0;
    out_ch.ready          = 1'b0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.index          = REG_CURRENT_LSB;
    cfg_ch.data           = '0;
    lsb_ua    = LSB_RESET;
    alpha_q   = ALPHA_RESET;
    level_q   = 0;
    primed_q  = 1'b0;
    hold_volt = '0;
    hold_cur  = '0;
    hold_pwr  = '0;
    hold_pct  = '0;
    calm      = 1'b0;

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed readings under the reset configuration.
    queue_reading(1'b0, 16'hFFFF, 16'h8000, 16'hFFFF);   // failed read before any good one
    queue_reading(1'b1, 16'hFFFF, 16'h8000, 16'hFFFF);   // top code, most negative current
    queue_reading(1'b1, 16'd10500, 16'h7FFF, 16'h0000);  // exactly on the top knee
    queue_reading(1'b1, 16'd10499, 16'hFFFF, 16'h0001);
    queue_reading(1'b1, 16'd7500, 16'h0000, 16'h8000);   // exactly on the bottom knee
    queue_reading(1'b1, 16'd7501, 16'h0001, 16'h7FFF);
    queue_reading(1'b1, 16'd7875, 16'h1234, 16'h5555);   // half step, rounds up to 1
    queue_reading(1'b1, 16'd7874, 16'hEDCB, 16'hAAAA);
    queue_reading(1'b1, 16'h0000, 16'h0000, 16'h0000);   // below the curve
    queue_reading(1'b0, 16'd9000, 16'h7FFF, 16'hFFFF);   // failed read holds everything
    queue_reading(1'b0, 16'h7FFF, 16'h8000, 16'h0000);
    queue_reading(1'b1, 16'd9000, 16'h0100, 16'h0200);   // re-prime on a knee
    queue_reading(1'b1, 16'h8000 | 16'd9937, 16'hFF00, 16'h00FF);  // top bit ignored
    for (int k = 0; k < 19; k += 2)
      queue_reading(1'b1, RAW_W'(knee_code[k] - 1), RAW_W'($urandom), RAW_W'($urandom));
    drain();

    // Settings per phase, extremes first; alpha 0 and above 256 saturate.
    lsb_plan   = '{14'd1, 14'd10000, 14'h3FFF, 14'd0, 14'd1000, 14'd1, 14'd1, 14'd1};
    alpha_plan = '{9'd1, 9'd256, 9'd0, 9'h1FF, 9'd300, 9'd26, 9'd128, 9'd1};
    for (int ph = 5; ph < PHASES; ph++) begin
      lsb_plan[ph]   = LSB_W'($urandom_range(1, 10000));
      alpha_plan[ph] = ALPHA_W'($urandom_range(1, 256));
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      write_reg(REG_CURRENT_LSB, lsb_plan[ph]);
      // Upper data bits are junk for the 9-bit alpha register.
      write_reg(REG_SMOOTH_ALPHA, {5'($urandom), alpha_plan[ph]});
      if (ph == 1) begin
        write_reg(REG_SPARE_2, CFG_DATA_W'($urandom));
        write_reg(REG_SPARE_3, CFG_DATA_W'($urandom));
      end
      if (ph == PHASES - 1) calm = 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = random_reading();
        queue_reading(r.ok, r.volt, r.cur, r.pwr);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (bad_reports == 0)
      $display("tb_battery_charge_estimator_unit OK");
    else
      $display("tb_battery_charge_estimator_unit NOT OK");
    $finish;
  end

endmodule

>>> battery_charge_estimator_unit.f
src/bce_pkg.sv
src/bce_if.sv
src/bce_ctrl.sv
src/bce_dpath.sv
src/battery_charge_estimator_unit.sv
test/tb_battery_charge_estimator_unit.sv
